FILE: hw/rtl/pcpa_pkg.sv
// shared types and constants for the per-cpu page free list allocator
`default_nettype none

package pcpa_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned CPU_IW  = 3;
  localparam int unsigned START_W = 20;
  localparam int unsigned END_W   = 21;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;

  localparam logic [START_W-1:0] START_RST = 20'd0;
  localparam logic [END_W-1:0]   END_RST   = 21'd4096;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

  localparam logic CMD_FREE  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ADDR = 2'd1,
    ST_NO_MEM   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_STEAL_HEAD,
    S_STEAL_POP,
    S_STEAL_LINK,
    S_REFILL_DONE,
    S_POP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic              command;
    logic [CPU_IW-1:0] cpu_index;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] page_address;
  } rsp_t;

  typedef struct packed {
    logic    accept;
    logic    free_push;
    logic    refill_init;
    logic    other_inc;
    logic    head_rd_other;
    logic    load_other_head;
    logic    link_rd_other_head;
    logic    steal_move;
    logic    pop_from_head;
    logic    pop_from_cpu_head;
    logic    pop_commit;
    logic    fin;
    status_e fin_status;
    logic    fin_page;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic free_bad;
    logic cpu_bad;
    logic head_nil;
    logic other_head_nil;
    logic cpu_head_nil;
    logic limit_hit;
    logic other_end;
    logic other_is_cpu;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pcpa_ram.sv
// generic single write port ram with registered read
`default_nettype none

module pcpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pcpa_ctrl.sv
// controller state machine sequencing free, pop and steal refill
`default_nettype none

module pcpa_ctrl import pcpa_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat_i.is_alloc) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = stat_i.free_bad ? ST_BAD_ADDR : ST_OK;
          cmd_o.free_push  = !stat_i.free_bad;
          cmd_o.load_out   = !stat_i.out_busy;
          state_d          = stat_i.out_busy ? S_RESP : S_IDLE;
        end else if (stat_i.cpu_bad) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = ST_NO_MEM;
          cmd_o.load_out   = !stat_i.out_busy;
          state_d          = stat_i.out_busy ? S_RESP : S_IDLE;
        end else if (stat_i.head_nil) begin
          cmd_o.refill_init = 1'b1;
          state_d           = S_SCAN;
        end else begin
          cmd_o.pop_from_head = 1'b1;
          state_d             = S_POP;
        end
      end
      S_SCAN: begin
        if (stat_i.limit_hit || stat_i.other_end) begin
          state_d = S_REFILL_DONE;
        end else if (stat_i.other_is_cpu) begin
          cmd_o.other_inc = 1'b1;
        end else begin
          cmd_o.head_rd_other = 1'b1;
          state_d             = S_STEAL_HEAD;
        end
      end
      S_STEAL_HEAD: begin
        cmd_o.load_other_head = 1'b1;
        state_d               = S_STEAL_POP;
      end
      S_STEAL_POP: begin
        if (stat_i.limit_hit) begin
          state_d = S_REFILL_DONE;
        end else if (stat_i.other_head_nil) begin
          cmd_o.other_inc = 1'b1;
          state_d         = S_SCAN;
        end else begin
          cmd_o.link_rd_other_head = 1'b1;
          state_d                  = S_STEAL_LINK;
        end
      end
      S_STEAL_LINK: begin
        cmd_o.steal_move = 1'b1;
        state_d          = S_STEAL_POP;
      end
      S_REFILL_DONE: begin
        if (stat_i.cpu_head_nil) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = ST_NO_MEM;
          cmd_o.load_out   = !stat_i.out_busy;
          state_d          = stat_i.out_busy ? S_RESP : S_IDLE;
        end else begin
          cmd_o.pop_from_cpu_head = 1'b1;
          state_d                 = S_POP;
        end
      end
      S_POP: begin
        cmd_o.pop_commit = 1'b1;
        cmd_o.fin        = 1'b1;
        cmd_o.fin_status = ST_OK;
        cmd_o.fin_page   = 1'b1;
        cmd_o.load_out   = !stat_i.out_busy;
        state_d          = stat_i.out_busy ? S_RESP : S_IDLE;
      end
      S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DECODE)
    else $error("accepted transaction not decoded next cycle");

  a_head_write_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.free_push, cmd_o.steal_move, cmd_o.pop_commit}))
    else $error("head store written from two sources");

  a_stash_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin && !cmd_o.load_out |=> state_q == S_RESP)
    else $error("stalled result not held for response");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/pcpa_dp.sv
// datapath with list heads, link store, steal counters and result register
`default_nettype none

module pcpa_dp import pcpa_pkg::*; #(
  parameter int unsigned CPUS       = 8,
  parameter int unsigned PAGES      = 4096,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire req_t                in_data_i,
  input  wire ctrl_cmd_t           cmd_i,
  output dp_stat_t                 stat_o,
  input  wire logic [START_W-1:0]  region_start_i,
  input  wire logic [END_W-1:0]    region_end_i,
  input  wire logic [LIMIT_W-1:0]  steal_limit_i,
  output rsp_t                     out_data_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i
);

  localparam int unsigned PW    = $clog2(PAGES + 1);
  localparam int unsigned LAW   = $clog2(PAGES);
  localparam int unsigned OFF_W = $clog2(PAGE_BYTES);
  localparam int unsigned CPU_W = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int unsigned OTH_W = $clog2(CPUS + 1);
  localparam int unsigned CIW   = (CPU_W > CPU_IW) ? CPU_W : CPU_IW;
  localparam int unsigned CMW   = (OTH_W > CPU_IW) ? OTH_W : CPU_IW;
  localparam logic [PW-1:0] NIL = PW'(PAGES);

  logic                  cmd_q;
  logic [CPU_IW-1:0]     cpu_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [PW-1:0]         page_q;
  logic [PW-1:0]         cpu_head_q;
  logic [PW-1:0]         other_head_q;
  logic [OTH_W-1:0]      other_q;
  logic [LIMIT_W-1:0]    moved_q;
  logic [CPUS-1:0]       head_vld_q;
  logic [CPU_W-1:0]      head_ridx_q;
  rsp_t                  res_q;
  rsp_t                  out_q;
  logic                  out_valid_q;

  logic [CIW-1:0]        cpu_ext;
  logic [CIW-1:0]        in_cpu_ext;
  logic [CPU_W-1:0]      cpu_idx;
  logic [CPU_W-1:0]      in_cpu_idx;
  logic [CPU_W-1:0]      other_idx;
  logic [ADDR_W-1:0]     addr_page;
  logic [PW-1:0]         head_rdata;
  logic [PW-1:0]         head_rd;
  logic [PW-1:0]         link_rdata;
  logic                  head_we;
  logic [CPU_W-1:0]      head_waddr;
  logic [PW-1:0]         head_wdata;
  logic                  head_re;
  logic [CPU_W-1:0]      head_raddr;
  logic                  link_we;
  logic [LAW-1:0]        link_waddr;
  logic [PW-1:0]         link_wdata;
  logic                  link_re;
  logic [LAW-1:0]        link_raddr;
  logic [PW-1:0]         pop_src;
  rsp_t                  fresh;

  assign cpu_ext    = CIW'(cpu_q);
  assign in_cpu_ext = CIW'(in_data_i.cpu_index);
  assign cpu_idx    = cpu_ext[CPU_W-1:0];
  assign in_cpu_idx = in_cpu_ext[CPU_W-1:0];
  assign other_idx  = other_q[CPU_W-1:0];
  assign addr_page  = addr_q >> OFF_W;
  assign head_rd    = head_vld_q[head_ridx_q] ? head_rdata : NIL;

  always_comb begin
    stat_o.is_alloc       = (cmd_q == CMD_ALLOC);
    stat_o.cpu_bad        = 32'(cpu_q) >= 32'(CPUS);
    stat_o.free_bad       = (|addr_q[OFF_W-1:0])
                         || (addr_page < 32'(region_start_i))
                         || (addr_page >= 32'(region_end_i))
                         || (addr_page >= 32'(PAGES))
                         || stat_o.cpu_bad;
    stat_o.head_nil       = (head_rd == NIL);
    stat_o.other_head_nil = (other_head_q == NIL);
    stat_o.cpu_head_nil   = (cpu_head_q == NIL);
    stat_o.limit_hit      = (moved_q >= steal_limit_i);
    stat_o.other_end      = (other_q == OTH_W'(CPUS));
    stat_o.other_is_cpu   = (CMW'(other_q) == CMW'(cpu_q));
    stat_o.out_busy       = out_valid_q && !out_ready_i;
  end

  // head store ports
  always_comb begin
    head_re    = cmd_i.accept || cmd_i.head_rd_other;
    head_raddr = cmd_i.accept ? in_cpu_idx : other_idx;
    head_we    = cmd_i.free_push || cmd_i.steal_move || cmd_i.pop_commit;
    head_waddr = cmd_i.steal_move ? other_idx : cpu_idx;
    if (cmd_i.free_push) begin
      head_wdata = addr_page[PW-1:0];
    end else begin
      head_wdata = link_rdata;
    end
  end

  // link store ports
  always_comb begin
    pop_src = cmd_i.pop_from_head ? head_rd : cpu_head_q;
    link_re = cmd_i.pop_from_head || cmd_i.pop_from_cpu_head || cmd_i.link_rd_other_head;
    if (cmd_i.link_rd_other_head) begin
      link_raddr = other_head_q[LAW-1:0];
    end else begin
      link_raddr = pop_src[LAW-1:0];
    end
    link_we = cmd_i.free_push || cmd_i.steal_move;
    if (cmd_i.free_push) begin
      link_waddr = addr_page[LAW-1:0];
      link_wdata = head_rd;
    end else begin
      link_waddr = other_head_q[LAW-1:0];
      link_wdata = cpu_head_q;
    end
  end

  pcpa_ram #(
    .WIDTH (PW),
    .DEPTH (CPUS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .re_i    (head_re),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  pcpa_ram #(
    .WIDTH (PW),
    .DEPTH (PAGES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  always_comb begin
    fresh.status       = cmd_i.fin_status;
    fresh.page_address = cmd_i.fin_page ? (32'(page_q) << OFF_W) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (head_we) begin
        head_vld_q[head_waddr] <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q  <= in_data_i.command;
      cpu_q  <= in_data_i.cpu_index;
      addr_q <= in_data_i.address;
    end
    if (head_re) begin
      head_ridx_q <= head_raddr;
    end
    if (cmd_i.pop_from_head || cmd_i.pop_from_cpu_head) begin
      page_q <= pop_src;
    end
    if (cmd_i.refill_init) begin
      other_q    <= '0;
      moved_q    <= '0;
      cpu_head_q <= NIL;
    end else begin
      if (cmd_i.other_inc) begin
        other_q <= other_q + 1'b1;
      end
      if (cmd_i.steal_move) begin
        cpu_head_q <= other_head_q;
        moved_q    <= moved_q + 1'b1;
      end
    end
    if (cmd_i.load_other_head) begin
      other_head_q <= head_rd;
    end else if (cmd_i.steal_move) begin
      other_head_q <= link_rdata;
    end
    if (cmd_i.fin) begin
      res_q <= fresh;
    end
    if (cmd_i.load_out) begin
      out_q <= cmd_i.fin ? fresh : res_q;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && !out_ready_i))
    else $error("pending result overwritten");

  a_move_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.steal_move |-> moved_q < steal_limit_i)
    else $error("refill moved past steal limit");

  a_pop_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_commit |-> page_q != NIL)
    else $error("pop of empty list committed");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/per_cpu_page_free_list_allocator.sv
// top level of the per-cpu page free list allocator with apb config registers
//
// usage: requests arrive on the in channel (valid/ready, payload req_t): a free
// pushes a page onto the given cpu's lifo list after checking alignment and the
// managed region, an allocate pops the head of that cpu's list. each transaction
// returns one response on the out channel (valid/ready, payload rsp_t).
// a free answers from the decode state once the registered head store read is back;
// an allocate from a non-empty list also reads the link store and answers from pop.
// an allocate that finds its list empty refills first by stealing from the other
// cpus; that walk visits each other cpu via scan, steal_head and steal_pop, moves
// each page via steal_link, at most steal_limit pages, all through the link store.
// one request is in flight at a time; a new one is taken while a finished response
// still waits in the output register.
// reset empties all lists; the link store is not cleared and needs no sweep.
// a stalled receiver holds the response; the next request completes its work and
// then waits until the output register is free.
// config registers sit on the apb port: 0 region_start_page, 4 region_end_page,
// 8 steal_limit; write them only while idle.
`default_nettype none

module per_cpu_page_free_list_allocator import pcpa_pkg::*; #(
  parameter int unsigned CPUS       = 8,
  parameter int unsigned PAGES      = 4096,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire req_t              in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rsp_t                   out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  logic [START_W-1:0] start_q;
  logic [END_W-1:0]   end_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               cfg_we;
  ctrl_cmd_t          cmd;
  dp_stat_t           stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RST;
      end_q   <= END_RST;
      limit_q <= LIMIT_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_START: start_q <= pwdata[START_W-1:0];
        REG_END:   end_q   <= pwdata[END_W-1:0];
        REG_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_START: prdata = APB_DW'(start_q);
      REG_END:   prdata = APB_DW'(end_q);
      REG_LIMIT: prdata = APB_DW'(limit_q);
      default:   prdata = '0;
    endcase
  end

  pcpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pcpa_dp #(
    .CPUS       (CPUS),
    .PAGES      (PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_data_i      (in_data_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .region_start_i (start_q),
    .region_end_i   (end_q),
    .steal_limit_i  (limit_q),
    .out_data_o     (out_data_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// self-checking testbench for the per-cpu page free list allocator
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcpa_pkg::*;

  localparam int unsigned N_CPU       = 8;
  localparam int unsigned N_PAGE      = 4096;
  localparam logic [12:0] NIL_PG      = 13'd4096;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  reg_idx;
    logic [31:0] cfg_val;
    req_t        req;
    logic        typed;
    rsp_t        want;
  } plan_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_MOSTLY} rx_mode_e;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  req_t              in_data   = '0;
  logic              out_ready = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic              in_ready_o;
  logic              out_valid_o;
  rsp_t              out_data_o;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic [START_W-1:0] cfg_start = START_RST;
  logic [END_W-1:0]   cfg_end   = END_RST;
  logic [LIMIT_W-1:0] cfg_limit = LIMIT_RST;
  logic [12:0]        free_head [N_CPU];
  logic [12:0]        next_pg [N_PAGE];

  rsp_t        page_replies [$];
  plan_row_t   plan [$];
  logic [11:0] spare_pages [$];
  int          listed        = 0;
  int          mismatches    = 0;
  int unsigned burst_left    = 0;
  logic        long_hold_req = 1'b0;

  per_cpu_page_free_list_allocator #(
    .CPUS      (N_CPU),
    .PAGES     (N_PAGE),
    .PAGE_BYTES(4096)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    end
  endtask

  function automatic rsp_t apply_page_request(input req_t r);
    rsp_t        res;
    logic [19:0] pg;
    logic [12:0] top;
    logic [6:0]  moved;
    int          other;
    res.status       = ST_OK;
    res.page_address = '0;
    if (r.command == CMD_FREE) begin
      pg = r.address[31:12];
      if (r.address[11:0] != 12'd0 || pg < cfg_start || {1'b0, pg} >= cfg_end ||
          pg >= 20'(N_PAGE)) begin
        res.status = ST_BAD_ADDR;
      end else begin
        next_pg[pg[11:0]]      = free_head[r.cpu_index];
        free_head[r.cpu_index] = pg[12:0];
      end
    end else begin
      if (free_head[r.cpu_index] == NIL_PG) begin
        moved = '0;
        for (other = 0; other < N_CPU && moved < cfg_limit; other++) begin
          if (other != r.cpu_index) begin
            while (moved < cfg_limit && free_head[other] != NIL_PG) begin
              top                    = free_head[other];
              free_head[other]       = next_pg[top[11:0]];
              next_pg[top[11:0]]     = free_head[r.cpu_index];
              free_head[r.cpu_index] = top;
              moved++;
            end
          end
        end
      end
      top = free_head[r.cpu_index];
      if (top == NIL_PG) begin
        res.status = ST_NO_MEM;
      end else begin
        free_head[r.cpu_index] = next_pg[top[11:0]];
        res.page_address       = {8'd0, top[11:0], 12'd0};
      end
    end
    return res;
  endfunction

  function automatic void plan_req(input logic cmd, input logic [2:0] cpu,
                                   input logic [31:0] addr, input logic typed = 1'b0,
                                   input status_e st = ST_OK, input logic [31:0] pa = 32'd0);
    plan_row_t row;
    row                   = '0;
    row.req.command       = cmd;
    row.req.cpu_index     = cpu;
    row.req.address       = addr;
    row.typed             = typed;
    row.want.status       = st;
    row.want.page_address = pa;
    plan.push_back(row);
  endfunction

  function automatic void plan_cfg(input logic [1:0] idx, input logic [31:0] val);
    plan_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.cfg_val = val;
    plan.push_back(row);
  endfunction

  task automatic apb_cycle(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_register(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] rd;
    apb_cycle(1'b0, idx, 32'd0, rd);
    if (rd !== want) flag_mismatch("register readback", rd, want);
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] rd;
    apb_cycle(1'b1, idx, val, rd);
    case (idx)
      REG_START: cfg_start = val[START_W-1:0];
      REG_END:   cfg_end   = val[END_W-1:0];
      REG_LIMIT: cfg_limit = val[LIMIT_W-1:0];
      default: ;
    endcase
    check_register(idx, val);
  endtask

  task automatic await_idle();
    if (in_valid) in_valid <= 1'b0;
    while (page_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic issue(input req_t r, input logic typed, input rsp_t typed_rsp,
                       output rsp_t pred);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    pred = apply_page_request(r);
    page_replies.push_back(typed ? typed_rsp : pred);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 24);
      gap        = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_random(input int count, input int squeeze_at);
    int          n;
    int          k;
    int          seg;
    int          free_pct;
    req_t        r;
    rsp_t        pred;
    logic [11:0] pg;
    seg      = 0;
    free_pct = 50;
    for (n = 0; n < count; n++) begin
      if (seg == 0) begin
        seg = $urandom_range(8, 60);
        case ($urandom_range(0, 2))
          0:       free_pct = 25;
          1:       free_pct = 50;
          default: free_pct = 80;
        endcase
      end
      seg--;
      if (n == squeeze_at) begin
        long_hold_req = 1'b1;
        burst_left    = 24;
      end
      if (n % 113 == 112) await_idle();
      r.cpu_index = 3'($urandom_range(0, N_CPU - 1));
      r.address   = $urandom();
      if ($urandom_range(0, 99) < 5) begin
        // malformed free: misaligned or beyond the page table
        r.command = CMD_FREE;
        if (r.address[31:24] == 8'd0 && r.address[11:0] == 12'd0) r.address[0] = 1'b1;
        issue(r, 1'b0, '0, pred);
      end else if (spare_pages.size() != 0 &&
                   $urandom_range(0, 99) < (listed > 48 ? 25 : free_pct)) begin
        k  = $urandom_range(0, spare_pages.size() - 1);
        pg = spare_pages[k];
        spare_pages.delete(k);
        r.command = CMD_FREE;
        r.address = {8'd0, pg, 12'd0};
        issue(r, 1'b0, '0, pred);
        if (pred.status == ST_OK) listed++;
        else spare_pages.push_back(pg);
      end else begin
        r.command = CMD_ALLOC;
        issue(r, 1'b0, '0, pred);
        if (pred.status == ST_OK) begin
          listed--;
          spare_pages.push_back(pred.page_address[23:12]);
        end
      end
    end
  endtask

  initial begin : receiver
    int       seg;
    int       tick;
    rx_mode_e rx_mode;
    seg     = 0;
    tick    = 0;
    rx_mode = RX_OPEN;
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        if (seg == 0) begin
          seg     = $urandom_range(20, 120);
          rx_mode = rx_mode_e'($urandom_range(0, 3));
        end
        seg--;
        tick++;
        case (rx_mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
          RX_EVERY4: out_ready <= (tick % 4 == 0);
          default:   out_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : reply_check
    rsp_t due;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready) begin
        if (page_replies.size() == 0) begin
          flag_mismatch("response with none pending", out_data_o.page_address, 32'd0);
        end else begin
          due = page_replies.pop_front();
          if (out_data_o.status !== due.status)
            flag_mismatch("status", 32'(out_data_o.status), 32'(due.status));
          if (out_data_o.page_address !== due.page_address)
            flag_mismatch("page_address", out_data_o.page_address, due.page_address);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main_flow
    rsp_t        pred;
    logic [31:0] lo;
    int          i;
    foreach (free_head[c]) free_head[c] = NIL_PG;

    plan_req(CMD_ALLOC, 3'd0, 32'h0000_0000, 1'b1, ST_NO_MEM);
    plan_req(CMD_FREE,  3'd0, 32'h0000_0000, 1'b1, ST_OK);
    plan_req(CMD_FREE,  3'd7, 32'h00FF_F000, 1'b1, ST_OK);
    plan_req(CMD_FREE,  3'd3, 32'h0100_0000, 1'b1, ST_BAD_ADDR);
    plan_req(CMD_FREE,  3'd2, 32'hFFFF_F000, 1'b1, ST_BAD_ADDR);
    plan_req(CMD_FREE,  3'd1, 32'h0000_0001, 1'b1, ST_BAD_ADDR);
    plan_req(CMD_FREE,  3'd6, 32'hFFFF_FFFF, 1'b1, ST_BAD_ADDR);
    plan_req(CMD_ALLOC, 3'd7, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h00FF_F000);
    plan_req(CMD_ALLOC, 3'd0, 32'h0000_0000, 1'b1, ST_OK, 32'h0000_0000);
    plan_req(CMD_FREE,  3'd5, 32'h0000_5000);
    plan_req(CMD_FREE,  3'd6, 32'h0000_6000);
    plan_req(CMD_ALLOC, 3'd0, 32'h0000_0000);
    plan_req(CMD_ALLOC, 3'd0, 32'h0000_0000);
    plan_req(CMD_ALLOC, 3'd3, 32'h0000_0000, 1'b1, ST_NO_MEM);
    // same page freed to two lists
    plan_req(CMD_FREE,  3'd2, 32'h0000_9000);
    plan_req(CMD_FREE,  3'd3, 32'h0000_9000);
    plan_req(CMD_ALLOC, 3'd2, 32'h0000_0000);
    plan_req(CMD_ALLOC, 3'd3, 32'h0000_0000);
    // no stealing at all
    plan_cfg(REG_LIMIT, 32'd0);
    plan_req(CMD_FREE,  3'd1, 32'h0000_2000);
    plan_req(CMD_ALLOC, 3'd0, 32'h0000_0000, 1'b1, ST_NO_MEM);
    plan_req(CMD_ALLOC, 3'd1, 32'h0000_0000, 1'b1, ST_OK, 32'h0000_2000);
    plan_cfg(REG_LIMIT, 32'd1);
    plan_req(CMD_FREE,  3'd4, 32'h0000_4000);
    plan_req(CMD_FREE,  3'd5, 32'h0000_5000);
    plan_req(CMD_ALLOC, 3'd0, 32'h0000_0000, 1'b1, ST_OK, 32'h0000_4000);
    plan_req(CMD_ALLOC, 3'd0, 32'h0000_0000, 1'b1, ST_OK, 32'h0000_5000);
    plan_cfg(REG_LIMIT, 32'd64);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_register(REG_START, 32'(START_RST));
    check_register(REG_END,   32'(END_RST));
    check_register(REG_LIMIT, 32'(LIMIT_RST));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        await_idle();
        set_register(plan[i].reg_idx, plan[i].cfg_val);
      end else begin
        issue(plan[i].req, plan[i].typed, plan[i].want, pred);
      end
    end
    await_idle();

    for (i = 0; i < N_PAGE; i++) spare_pages.push_back(12'(i));
    listed = 0;

    run_random(250, 40);

    await_idle();
    set_register(REG_LIMIT, 32'd1);
    run_random(250, -1);

    await_idle();
    set_register(REG_LIMIT, 32'd0);
    run_random(120, -1);

    await_idle();
    lo = $urandom_range(1, 2500);
    set_register(REG_START, lo);
    set_register(REG_END, lo + $urandom_range(16, 1600));
    set_register(REG_LIMIT, $urandom_range(2, 63));
    run_random(250, -1);

    await_idle();
    set_register(REG_START, 32'd1048575);
    set_register(REG_END, 32'd1048576);
    set_register(REG_LIMIT, 32'd127);
    run_random(60, -1);

    await_idle();
    set_register(REG_START, 32'd0);
    set_register(REG_END, 32'd0);
    set_register(REG_LIMIT, 32'd64);
    run_random(60, -1);

    await_idle();
    set_register(REG_END, 32'd1048576);
    set_register(REG_LIMIT, 32'd3);
    run_random(300, 150);

    await_idle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
